>>> rtl/core/mpa_pkg.sv
// mpa_pkg: shared constants, register codes and control structs for the
// max pooling with argmax core.
// No dependencies; used by every module in rtl/core.
package mpa_pkg;

	// Default values for the top-level parameters
	localparam int STORE_DEPTH_DEF = 65536;
	localparam int MAX_WINDOW_DEF  = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	// Flat image index: row*W*C + col*C + channel, up to 1024*1024*64
	localparam int FLAT_W    = 26;
	// Reported index bits
	localparam int IDX_W     = 16;
	// Window size counters (covers window sizes up to 16)
	localparam int WIN_CNT_W = 5;
	// W*C, up to 65536
	localparam int ROW_STR_W = 17;

	// APB port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
	localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
	localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd4;
	localparam logic [2:0] REG_WINDOW_STRIDE = 3'd5;
	localparam logic [2:0] REG_INDEX_ENABLE  = 3'd6;

	// Register reset values
	localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd8;
	localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd8;
	localparam logic [6:0]  RST_CHANNEL_COUNT = 7'd1;
	localparam logic [3:0]  RST_WINDOW_WIDTH  = 4'd2;
	localparam logic [3:0]  RST_WINDOW_HEIGHT = 4'd2;
	localparam logic [3:0]  RST_WINDOW_STRIDE = 4'd2;

	// Upper bounds applied to register values
	localparam logic [10:0] IMG_MAX    = 11'd1024;
	localparam logic [6:0]  CHS_MAX    = 7'd64;
	localparam logic [3:0]  STRIDE_MAX = 4'd8;

	// Cycles input stays blocked after a register write (derived terms settle)
	localparam logic [1:0] CFG_SETTLE = 2'd2;

	// Effective geometry and derived terms, config block to datapath
	typedef struct packed {
		logic [10:0]           w;
		logic [10:0]           h;
		logic [6:0]            chs;
		logic [WIN_CNT_W-1:0]  fw;
		logic [WIN_CNT_W-1:0]  fh;
		logic [3:0]            stride;
		logic                  idx_en;
		logic [ROW_STR_W-1:0]  row_stride;
		logic [FLAT_W-1:0]     win_back;
		logic                  settle;
		logic                  restart;
	} geom_t;

	// Raster position status for the sample at the input
	typedef struct packed {
		logic [FLAT_W-1:0] here;
		logic              trig;
		logic              last;
	} pos_t;

endpackage

>>> rtl/core/mpa_cfg.sv
// mpa_cfg: APB register file, value clamping and derived geometry terms
// (row stride W*C and window back-offset). Depends on mpa_pkg.
module mpa_cfg #(
	parameter int MAX_WINDOW = mpa_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [mpa_pkg::PDATA_W-1:0]  pwdata,
	output logic [mpa_pkg::PDATA_W-1:0]  prdata,
	output mpa_pkg::geom_t               geom
);

	logic [10:0] img_w_q, img_h_q;
	logic [6:0]  chs_q;
	logic [3:0]  win_w_q, win_h_q, stride_q;
	logic        idx_en_q;
	logic [1:0]  settle_q;

	logic [mpa_pkg::ROW_STR_W-1:0] row_stride_q;
	logic [mpa_pkg::FLAT_W-1:0]    win_back_q;

	logic                          wr;
	logic [2:0]                    reg_sel;
	logic [10:0]                   w_c, h_c;
	logic [6:0]                    chs_c;
	logic [mpa_pkg::WIN_CNT_W-1:0] fw_c, fh_c, win_max, fw_raw, fh_raw;
	logic [3:0]                    s_c;

	assign wr      = psel & penable & pwrite;
	assign reg_sel = paddr[mpa_pkg::PADDR_W-1:2];
	assign win_max = mpa_pkg::WIN_CNT_W'(MAX_WINDOW);
	assign fw_raw  = mpa_pkg::WIN_CNT_W'(win_w_q);
	assign fh_raw  = mpa_pkg::WIN_CNT_W'(win_h_q);

	// Register writes; derived terms also settle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= mpa_pkg::RST_IMAGE_WIDTH;
			img_h_q  <= mpa_pkg::RST_IMAGE_HEIGHT;
			chs_q    <= mpa_pkg::RST_CHANNEL_COUNT;
			win_w_q  <= mpa_pkg::RST_WINDOW_WIDTH;
			win_h_q  <= mpa_pkg::RST_WINDOW_HEIGHT;
			stride_q <= mpa_pkg::RST_WINDOW_STRIDE;
			idx_en_q <= 1'b0;
			settle_q <= mpa_pkg::CFG_SETTLE;
		end else if (wr) begin
			unique case (reg_sel)
				mpa_pkg::REG_IMAGE_WIDTH:   img_w_q  <= pwdata[10:0];
				mpa_pkg::REG_IMAGE_HEIGHT:  img_h_q  <= pwdata[10:0];
				mpa_pkg::REG_CHANNEL_COUNT: chs_q    <= pwdata[6:0];
				mpa_pkg::REG_WINDOW_WIDTH:  win_w_q  <= pwdata[3:0];
				mpa_pkg::REG_WINDOW_HEIGHT: win_h_q  <= pwdata[3:0];
				mpa_pkg::REG_WINDOW_STRIDE: stride_q <= pwdata[3:0];
				mpa_pkg::REG_INDEX_ENABLE:  idx_en_q <= pwdata[0];
				default: ;
			endcase
			settle_q <= mpa_pkg::CFG_SETTLE;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// Readback
	always_comb begin
		unique case (reg_sel)
			mpa_pkg::REG_IMAGE_WIDTH:   prdata = mpa_pkg::PDATA_W'(img_w_q);
			mpa_pkg::REG_IMAGE_HEIGHT:  prdata = mpa_pkg::PDATA_W'(img_h_q);
			mpa_pkg::REG_CHANNEL_COUNT: prdata = mpa_pkg::PDATA_W'(chs_q);
			mpa_pkg::REG_WINDOW_WIDTH:  prdata = mpa_pkg::PDATA_W'(win_w_q);
			mpa_pkg::REG_WINDOW_HEIGHT: prdata = mpa_pkg::PDATA_W'(win_h_q);
			mpa_pkg::REG_WINDOW_STRIDE: prdata = mpa_pkg::PDATA_W'(stride_q);
			mpa_pkg::REG_INDEX_ENABLE:  prdata = mpa_pkg::PDATA_W'(idx_en_q);
			default:                    prdata = '0;
		endcase
	end

	// Zero counts as one, anything above the bound counts as the bound
	always_comb begin
		w_c   = (img_w_q == 11'd0) ? 11'd1 :
			(img_w_q > mpa_pkg::IMG_MAX) ? mpa_pkg::IMG_MAX : img_w_q;
		h_c   = (img_h_q == 11'd0) ? 11'd1 :
			(img_h_q > mpa_pkg::IMG_MAX) ? mpa_pkg::IMG_MAX : img_h_q;
		chs_c = (chs_q == 7'd0) ? 7'd1 :
			(chs_q > mpa_pkg::CHS_MAX) ? mpa_pkg::CHS_MAX : chs_q;
		fw_c  = (fw_raw == '0) ? mpa_pkg::WIN_CNT_W'(1) :
			(fw_raw > win_max) ? win_max : fw_raw;
		fh_c  = (fh_raw == '0) ? mpa_pkg::WIN_CNT_W'(1) :
			(fh_raw > win_max) ? win_max : fh_raw;
		s_c   = (stride_q == 4'd0) ? 4'd1 :
			(stride_q > mpa_pkg::STRIDE_MAX) ? mpa_pkg::STRIDE_MAX : stride_q;
	end

	// Derived terms, registered: W*C, then (FH-1)*W*C + (FW-1)*C from the registered W*C
	always_ff @(posedge clk) begin
		row_stride_q <= mpa_pkg::ROW_STR_W'(w_c) * mpa_pkg::ROW_STR_W'(chs_c);
		win_back_q   <= mpa_pkg::FLAT_W'(fh_c - mpa_pkg::WIN_CNT_W'(1))
				* mpa_pkg::FLAT_W'(row_stride_q)
			+ mpa_pkg::FLAT_W'(fw_c - mpa_pkg::WIN_CNT_W'(1))
				* mpa_pkg::FLAT_W'(chs_c);
	end

	always_comb begin
		geom.w          = w_c;
		geom.h          = h_c;
		geom.chs        = chs_c;
		geom.fw         = fw_c;
		geom.fh         = fh_c;
		geom.stride     = s_c;
		geom.idx_en     = idx_en_q;
		geom.row_stride = row_stride_q;
		geom.win_back   = win_back_q;
		geom.settle     = (settle_q != 2'd0);
		// any geometry register write restarts the image
		geom.restart    = wr && (reg_sel < mpa_pkg::REG_INDEX_ENABLE);
	end

endmodule

>>> rtl/core/mpa_raster.sv
// mpa_raster: row/column/channel position, flat index and window-close
// detection with per-axis stride phase counters. Depends on mpa_pkg.
module mpa_raster (
	input  logic           clk,
	input  logic           arst_n,
	input  mpa_pkg::geom_t geom,
	input  logic           advance,
	output mpa_pkg::pos_t  pos
);

	logic [9:0]                 r_q, c_q;
	logic [5:0]                 ch_q;
	logic [2:0]                 rph_q, cph_q;
	logic [mpa_pkg::FLAT_W-1:0] here_q;

	logic [10:0] r_inc, c_inc;
	logic [6:0]  ch_inc;
	logic        ch_wrap, c_wrap, r_wrap;
	logic        fits, row_in, col_in;
	logic [2:0]  cph_next, rph_next;

	assign r_inc  = {1'b0, r_q} + 11'd1;
	assign c_inc  = {1'b0, c_q} + 11'd1;
	assign ch_inc = {1'b0, ch_q} + 7'd1;

	assign ch_wrap = (ch_inc >= geom.chs);
	assign c_wrap  = (c_inc >= geom.w);
	assign r_wrap  = (r_inc >= geom.h);

	// Window closes at this sample
	assign fits   = (11'(geom.fw) <= geom.w) && (11'(geom.fh) <= geom.h);
	assign row_in = (r_inc >= 11'(geom.fh));
	assign col_in = (c_inc >= 11'(geom.fw));

	always_comb begin
		pos.here = here_q;
		pos.trig = fits && row_in && col_in && (rph_q == 3'd0) && (cph_q == 3'd0);
		// last window row, last window column, last channel
		pos.last = (ch_inc == geom.chs)
			&& (({1'b0, r_q} + 11'(geom.stride)) >= geom.h)
			&& (({1'b0, c_q} + 11'(geom.stride)) >= geom.w);
	end

	// Stride phase: zero up to the first window edge, then counts modulo stride
	always_comb begin
		if (c_inc < 11'(geom.fw))
			cph_next = 3'd0;
		else if (({1'b0, cph_q} + 4'd1) == geom.stride)
			cph_next = 3'd0;
		else
			cph_next = cph_q + 3'd1;
		if (r_inc < 11'(geom.fh))
			rph_next = 3'd0;
		else if (({1'b0, rph_q} + 4'd1) == geom.stride)
			rph_next = 3'd0;
		else
			rph_next = rph_q + 3'd1;
	end

	// Position advance per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			c_q    <= '0;
			ch_q   <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			here_q <= '0;
		end else if (geom.restart) begin
			r_q    <= '0;
			c_q    <= '0;
			ch_q   <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			here_q <= '0;
		end else if (advance) begin
			here_q <= (ch_wrap && c_wrap && r_wrap) ? '0 :
				here_q + mpa_pkg::FLAT_W'(1);
			if (ch_wrap) begin
				ch_q <= '0;
				if (c_wrap) begin
					c_q   <= '0;
					cph_q <= '0;
					if (r_wrap) begin
						r_q   <= '0;
						rph_q <= '0;
					end else begin
						r_q   <= r_inc[9:0];
						rph_q <= rph_next;
					end
				end else begin
					c_q   <= c_inc[9:0];
					cph_q <= cph_next;
				end
			end else begin
				ch_q <= ch_inc[5:0];
			end
		end
	end

endmodule

>>> rtl/core/mpa_store.sv
// mpa_store: single-port-write, single-port-read sample memory with a
// registered read. Depends on mpa_pkg for defaults.
module mpa_store #(
	parameter int DEPTH  = mpa_pkg::STORE_DEPTH_DEF,
	parameter int DATA_W = mpa_pkg::SAMPLE_BITS_DEF,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Contents undefined until written; no clearing
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/mpa_scan.sv
// mpa_scan: input handshake, sample write, window scan over the store,
// running strict-greater maximum and the result register.
// Depends on mpa_pkg; drives mpa_store ports, fed by mpa_raster and mpa_cfg.
module mpa_scan #(
	parameter int STORE_DEPTH = mpa_pkg::STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF,
	localparam int AW         = $clog2(STORE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mpa_pkg::geom_t             geom,
	input  mpa_pkg::pos_t              pos,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic [SAMPLE_BITS-1:0]     sample_value,
	output logic                       advance,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [SAMPLE_BITS-1:0]     wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [SAMPLE_BITS-1:0]     rd_data,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [SAMPLE_BITS-1:0]     max_value,
	output logic [mpa_pkg::IDX_W-1:0]  max_index,
	output logic                       index_valid,
	output logic                       last_of_image
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EMIT
	} state_t;

	localparam logic [SAMPLE_BITS-1:0] FLOOR = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	state_t state_q;

	// scan address generation
	logic [mpa_pkg::FLAT_W-1:0]    addr_q, row_base_q;
	logic [mpa_pkg::WIN_CNT_W-1:0] m_q, n_q;
	// read pipeline
	logic                          vld_s1;
	logic [mpa_pkg::IDX_W-1:0]     flat_s1;
	// running best
	logic [SAMPLE_BITS-1:0]        best_q;
	logic [mpa_pkg::IDX_W-1:0]     bidx_q;
	logic                          bval_q, last_img_q;

	logic                          col_end, scan_fin, start, emit;
	logic [mpa_pkg::FLAT_W-1:0]    top_left, next_row;

	assign sample_ready = (state_q == S_IDLE) && !geom.settle;
	assign advance      = sample_valid && sample_ready;
	assign start        = advance && pos.trig;
	// result register loads when empty or being drained this cycle
	assign emit         = (state_q == S_EMIT) && (!result_valid || result_ready);

	// every accepted sample is stored at its flat index
	assign wr_en   = advance;
	assign wr_addr = pos.here[AW-1:0];
	assign wr_data = sample_value;
	assign rd_en   = (state_q == S_SCAN);
	assign rd_addr = addr_q[AW-1:0];

	assign col_end  = (m_q == geom.fw - mpa_pkg::WIN_CNT_W'(1));
	assign scan_fin = col_end && (n_q == geom.fh - mpa_pkg::WIN_CNT_W'(1));
	assign top_left = pos.here - geom.win_back;
	assign next_row = row_base_q + mpa_pkg::FLAT_W'(geom.row_stride);

	// Control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vld_s1        <= 1'b0;
			result_valid  <= 1'b0;
			max_value     <= '0;
			max_index     <= '0;
			index_valid   <= 1'b0;
			last_of_image <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			if (result_valid && result_ready && !emit)
				result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_fin)
						state_q <= S_DRAIN;
				end
				// last read data is compared here
				S_DRAIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit) begin
						result_valid  <= 1'b1;
						max_value     <= best_q;
						max_index     <= (geom.idx_en && bval_q) ? bidx_q : '0;
						index_valid   <= bval_q;
						last_of_image <= last_img_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Scan datapath
	always_ff @(posedge clk) begin
		if (start) begin
			addr_q     <= top_left;
			row_base_q <= top_left;
			m_q        <= '0;
			n_q        <= '0;
			best_q     <= FLOOR;
			bidx_q     <= '0;
			bval_q     <= 1'b0;
			last_img_q <= pos.last;
		end else if (state_q == S_SCAN) begin
			flat_s1 <= addr_q[mpa_pkg::IDX_W-1:0];
			if (col_end) begin
				m_q        <= '0;
				n_q        <= n_q + mpa_pkg::WIN_CNT_W'(1);
				row_base_q <= next_row;
				addr_q     <= next_row;
			end else begin
				m_q    <= m_q + mpa_pkg::WIN_CNT_W'(1);
				addr_q <= addr_q + mpa_pkg::FLAT_W'(geom.chs);
			end
		end
		// strict greater: first maximum in scan order wins
		if (vld_s1 && ($signed(rd_data) > $signed(best_q))) begin
			best_q <= rd_data;
			bidx_q <= flat_s1;
			bval_q <= 1'b1;
		end
	end

endmodule

>>> rtl/core/max_pool_window_argmax_core.sv
// max_pool_window_argmax_core: top level of the max pooling with argmax core.
// Depends on mpa_pkg, mpa_cfg, mpa_raster, mpa_store and mpa_scan.
//
//   Channel   Handshake                     Payload
//   config    APB psel/penable/pwrite       paddr[4:0], pwdata/prdata 32b
//   sample    sample_valid/sample_ready     sample_value
//   result    result_valid/result_ready     max_value, max_index,
//                                           index_valid, last_of_image
//
// A sample that closes no window is only written to the store. A sample that
// closes a window is accepted, then its window is read over the store's single
// read port, the last read data is compared and the result register is loaded;
// no sample is taken meanwhile. Reset clears positions and registers; the store
// is not cleared. After reset or a register write, samples are held off while
// W*C and the window offset recompute. A waiting result does not block the next
// sample; a second window result waits until the first transaction completes.
// The store is addressed by the low bits of the flat index (power-of-two depth).
module max_pool_window_argmax_core #(
	parameter int STORE_DEPTH = mpa_pkg::STORE_DEPTH_DEF,
	parameter int MAX_WINDOW  = mpa_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mpa_pkg::PADDR_W-1:0] paddr,
	input  logic [mpa_pkg::PDATA_W-1:0] pwdata,
	output logic [mpa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic [SAMPLE_BITS-1:0]      sample_value,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [SAMPLE_BITS-1:0]      max_value,
	output logic [mpa_pkg::IDX_W-1:0]   max_index,
	output logic                        index_valid,
	output logic                        last_of_image
);

	localparam int AW = $clog2(STORE_DEPTH);

	mpa_pkg::geom_t         geom;
	mpa_pkg::pos_t          pos;
	logic                   advance;
	logic                   wr_en, rd_en;
	logic [AW-1:0]          wr_addr, rd_addr;
	logic [SAMPLE_BITS-1:0] wr_data, rd_data;

	assign pready = 1'b1;

	mpa_cfg #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.geom    (geom)
	);

	mpa_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.advance (advance),
		.pos     (pos)
	);

	mpa_store #(
		.DEPTH  (STORE_DEPTH),
		.DATA_W (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mpa_scan #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.geom          (geom),
		.pos           (pos),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample_value  (sample_value),
		.advance       (advance),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.max_value     (max_value),
		.max_index     (max_index),
		.index_valid   (index_valid),
		.last_of_image (last_of_image)
	);

endmodule

>>> verif/max_pool_window_argmax_core_tb.sv
// Self-checking testbench for max_pool_window_argmax_core: streams image samples,
// predicts every pooled maximum and its index, and checks each result transaction.
// Depends on mpa_pkg and the core RTL only.
`timescale 1ns / 100ps

module max_pool_window_argmax_core_tb;

	localparam int SW            = mpa_pkg::SAMPLE_BITS_DEF;
	localparam int STORE_ENTRIES = mpa_pkg::STORE_DEPTH_DEF;
	localparam int REG_COUNT     = 7;
	// longest window scan (8x8 reads) plus register settle, rounded up
	localparam int SCAN_LATENCY  = 80;
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 400;
	localparam int MAX_REPORTS   = 20;

	typedef struct packed {
		logic [SW-1:0]             peak;
		logic [mpa_pkg::IDX_W-1:0] peak_index;
		logic                      peak_found;
		logic                      image_end;
	} pool_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [mpa_pkg::PADDR_W-1:0] paddr = '0;
	logic [mpa_pkg::PDATA_W-1:0] pwdata = '0;
	logic [mpa_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	logic                        sample_valid = 1'b0;
	logic                        sample_ready;
	logic [SW-1:0]               sample_value = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	logic [SW-1:0]               max_value;
	logic [mpa_pkg::IDX_W-1:0]   max_index;
	logic                        index_valid;
	logic                        last_of_image;

	// Shadow registers and raster position of the predictor
	logic [10:0] cfg_w = mpa_pkg::RST_IMAGE_WIDTH;
	logic [10:0] cfg_h = mpa_pkg::RST_IMAGE_HEIGHT;
	logic [6:0]  cfg_chs = mpa_pkg::RST_CHANNEL_COUNT;
	logic [3:0]  cfg_fw = mpa_pkg::RST_WINDOW_WIDTH;
	logic [3:0]  cfg_fh = mpa_pkg::RST_WINDOW_HEIGHT;
	logic [3:0]  cfg_stride = mpa_pkg::RST_WINDOW_STRIDE;
	logic        cfg_idx_en = 1'b0;
	logic [9:0]  row_pos = '0;
	logic [9:0]  col_pos = '0;
	logic [5:0]  ch_pos = '0;
	logic signed [SW-1:0] sample_mirror [STORE_ENTRIES];

	pool_result_t pending_pools [$];
	pool_result_t oldest;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	max_pool_window_argmax_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_dim(input int v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(3));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] shadow_reg(input logic [2:0] idx);
		case (idx)
			mpa_pkg::REG_IMAGE_WIDTH:   return 32'(cfg_w);
			mpa_pkg::REG_IMAGE_HEIGHT:  return 32'(cfg_h);
			mpa_pkg::REG_CHANNEL_COUNT: return 32'(cfg_chs);
			mpa_pkg::REG_WINDOW_WIDTH:  return 32'(cfg_fw);
			mpa_pkg::REG_WINDOW_HEIGHT: return 32'(cfg_fh);
			mpa_pkg::REG_WINDOW_STRIDE: return 32'(cfg_stride);
			mpa_pkg::REG_INDEX_ENABLE:  return 32'(cfg_idx_en);
			default:                    return 32'd0;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, name, want, got);
		end
	endtask

	// Store the sample, scan the window it closes (if any), advance the raster
	task automatic pool_predict(input logic [SW-1:0] raw);
		int w, h, chs, fw, fh, s;
		int r, c, ch, here, top, left, f, best_idx;
		logic signed [SW-1:0] best, v;
		bit found;
		pool_result_t res;
		w = clamp_dim(cfg_w, mpa_pkg::IMG_MAX);
		h = clamp_dim(cfg_h, mpa_pkg::IMG_MAX);
		chs = clamp_dim(cfg_chs, mpa_pkg::CHS_MAX);
		fw = clamp_dim(cfg_fw, mpa_pkg::MAX_WINDOW_DEF);
		fh = clamp_dim(cfg_fh, mpa_pkg::MAX_WINDOW_DEF);
		s = clamp_dim(cfg_stride, mpa_pkg::STRIDE_MAX);
		r = row_pos;
		c = col_pos;
		ch = ch_pos;
		here = r * w * chs + c * chs + ch;
		sample_mirror[here % STORE_ENTRIES] = raw;

		if (fw <= w && fh <= h && r + 1 >= fh && c + 1 >= fw &&
				(r + 1 - fh) % s == 0 && (c + 1 - fw) % s == 0) begin
			top = r + 1 - fh;
			left = c + 1 - fw;
			best = 16'sh8000;
			best_idx = 0;
			found = 1'b0;
			// strictly greater: first maximum in scan order wins
			for (int n = 0; n < fh; n++) begin
				for (int m = 0; m < fw; m++) begin
					f = (top + n) * w * chs + (left + m) * chs + ch;
					v = sample_mirror[f % STORE_ENTRIES];
					if (v > best) begin
						best = v;
						best_idx = f;
						found = 1'b1;
					end
				end
			end
			res.peak = best;
			res.peak_index = (cfg_idx_en && found) ? 16'(best_idx) : '0;
			res.peak_found = found;
			res.image_end = (top / s == (h - fh) / s) && (left / s == (w - fw) / s) &&
				(ch + 1 == chs);
			pending_pools.push_back(res);
		end

		ch++;
		if (ch >= chs) begin
			ch = 0;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h)
					r = 0;
			end
		end
		row_pos = 10'(r);
		col_pos = 10'(c);
		ch_pos = 6'(ch);
	endtask

	// One sample transaction; valid is left high so back-to-back items stay gapless
	task automatic send_sample(input logic [SW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_value <= v;
		do @(posedge clk); while (!sample_ready);
		pool_predict(v);
	endtask

	task automatic hold_until_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_pools.size() != 0)
			@(posedge clk);
	endtask

	// Block must be idle before a register write; a sample closing no window
	// may still be in flight, so let the scan latency pass too
	task automatic drain_and_settle();
		hold_until_drained();
		repeat (SCAN_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			mpa_pkg::REG_IMAGE_WIDTH:   cfg_w = value[10:0];
			mpa_pkg::REG_IMAGE_HEIGHT:  cfg_h = value[10:0];
			mpa_pkg::REG_CHANNEL_COUNT: cfg_chs = value[6:0];
			mpa_pkg::REG_WINDOW_WIDTH:  cfg_fw = value[3:0];
			mpa_pkg::REG_WINDOW_HEIGHT: cfg_fh = value[3:0];
			mpa_pkg::REG_WINDOW_STRIDE: cfg_stride = value[3:0];
			mpa_pkg::REG_INDEX_ENABLE:  cfg_idx_en = value[0];
			default: ;
		endcase
		// geometry writes restart the image
		if (idx != mpa_pkg::REG_INDEX_ENABLE) begin
			row_pos = '0;
			col_pos = '0;
			ch_pos = '0;
		end
		@(posedge clk);
	endtask

	task automatic read_check_reg(input logic [2:0] idx);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("register readback", shadow_reg(idx), got);
		@(posedge clk);
	endtask

	task automatic program_geometry(input int w, input int h, input int c, input int fw,
			input int fh, input int s, input int ie);
		drain_and_settle();
		write_reg(mpa_pkg::REG_IMAGE_WIDTH, w);
		write_reg(mpa_pkg::REG_IMAGE_HEIGHT, h);
		write_reg(mpa_pkg::REG_CHANNEL_COUNT, c);
		write_reg(mpa_pkg::REG_WINDOW_WIDTH, fw);
		write_reg(mpa_pkg::REG_WINDOW_HEIGHT, fh);
		write_reg(mpa_pkg::REG_WINDOW_STRIDE, s);
		write_reg(mpa_pkg::REG_INDEX_ENABLE, ie);
	endtask

	task automatic set_idle_mode(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
			default: begin send_idle_pct = 22; recv_stall_pct = 22; end
		endcase
	endtask

	// Reset values, then random writes with junk in the unused upper bits
	task automatic test_register_readback();
		for (int i = 0; i < REG_COUNT; i++)
			read_check_reg(3'(i));
		for (int i = 0; i < REG_COUNT; i++) begin
			write_reg(3'(i), $urandom());
			read_check_reg(3'(i));
		end
	endtask

	// Small image: all-floor window, tie, extremes; then a window larger than the image
	task automatic test_directed_windows();
		logic [SW-1:0] pattern [16] = '{
			16'h8000, 16'h8000, 16'h0005, 16'h0005,
			16'h8000, 16'h8000, 16'h0005, 16'h0005,
			16'h7FFF, 16'hFFFF, 16'h5555, 16'hAAAA,
			16'h0000, 16'h7FFF, 16'h0001, 16'h7FFE};
		set_idle_mode(0);
		program_geometry(4, 4, 1, 2, 2, 2, 1);
		foreach (pattern[i])
			send_sample(pattern[i]);
		program_geometry(2, 2, 1, 3, 3, 1, 0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
		send_sample(16'hFFFE);
	endtask

	// Zero counts as one, oversized values clamp to the upper bounds
	task automatic test_register_clamping();
		set_idle_mode(3);
		program_geometry(0, 0, 0, 0, 0, 0, 1);
		repeat (6) send_sample(pick_sample());
		// 127 channels count as 64, stride 15 as 8
		set_idle_mode(2);
		program_geometry(1, 2, 127, 0, 2, 15, 1);
		repeat (128) send_sample(pick_sample());
		// 15x15 window counts as 8x8: one window over the whole image
		set_idle_mode(1);
		program_geometry(8, 8, 0, 15, 15, 15, 1);
		repeat (64) send_sample(pick_sample());
		// oversized width or height, start of the first row or column only
		set_idle_mode(0);
		program_geometry(2047, 0, 0, 15, 1, 8, 1);
		repeat (64) send_sample(pick_sample());
		program_geometry(1, 2047, 1, 1, 8, 8, 0);
		repeat (64) send_sample(pick_sample());
	endtask

	// Random geometries, mostly whole images, some cut short by a restart
	task automatic test_random_images();
		int sent, phase, w, h, c, fw, fh, s, n;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			w = $urandom_range(1, 10);
			h = $urandom_range(1, 10);
			c = $urandom_range(1, 3);
			fw = ($urandom_range(7) == 0) ? mpa_pkg::MAX_WINDOW_DEF : $urandom_range(1, 4);
			fh = ($urandom_range(7) == 0) ? mpa_pkg::MAX_WINDOW_DEF : $urandom_range(1, 4);
			s = ($urandom_range(7) == 0) ? int'(mpa_pkg::STRIDE_MAX) : $urandom_range(1, 4);
			n = w * h * c * $urandom_range(1, 2);
			if ($urandom_range(5) == 0)
				n = $urandom_range(1, n);
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			program_geometry((w == 1 && $urandom_range(1)) ? 0 : w, h, c,
				(fw == 1 && $urandom_range(1)) ? 0 : fw, fh, s, $urandom_range(1));
			set_idle_mode(phase++);
			for (int k = 0; k < n; k++) begin
				if (k == n / 2 || $urandom_range(99) == 0)
					hold_until_drained();
				// index enable flip mid-image keeps the raster position
				if ($urandom_range(249) == 0) begin
					drain_and_settle();
					write_reg(mpa_pkg::REG_INDEX_ENABLE, {31'd0, ~cfg_idx_en});
				end
				send_sample(pick_sample());
			end
			sent += n;
		end
	endtask

	// Result side: random stall, compare against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (result_valid && result_ready) begin
				if (pending_pools.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t ns: unexpected result, expected none, actual %h/%h",
							$time, max_value, max_index);
				end else begin
					oldest = pending_pools.pop_front();
					check_field("max_value", oldest.peak, max_value);
					check_field("max_index", oldest.peak_index, max_index);
					check_field("index_valid", oldest.peak_found, index_valid);
					check_field("last_of_image", oldest.image_end, last_of_image);
				end
			end
		end
	end

	// Watchdog: too long without any transaction ends the run
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
				(psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_readback();
		test_directed_windows();
		test_register_clamping();
		test_random_images();
		drain_and_settle();
		if (mismatches == 0 && pending_pools.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> max_pool_window_argmax_core.f
rtl/core/mpa_pkg.sv
rtl/core/mpa_cfg.sv
rtl/core/mpa_raster.sv
rtl/core/mpa_store.sv
rtl/core/mpa_scan.sv
rtl/core/max_pool_window_argmax_core.sv
verif/max_pool_window_argmax_core_tb.sv
